/* design/rgbf_pkg.sv */
package rgbf_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int MIN_DIM    = 3;
    localparam int LINE_AW    = $clog2(MAX_WIDTH);
    localparam int DIM_W      = 9;
    localparam int ROW_W      = 9;
    localparam int RC_W       = ROW_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam int OUT_DEPTH  = 8;
    localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
    localparam int CREDIT_W   = $clog2(OUT_DEPTH + 1);
    localparam int SUM_W      = 12;
    localparam int ARITH_W    = 14;
    localparam int BLUR_RECIP = 7282;
    localparam int BLUR_SHIFT = 16;
    localparam int SHARP_GAIN = 10;

    typedef enum logic [1:0] {
        MODE_PASS    = 2'd0,
        MODE_BLUR    = 2'd1,
        MODE_SHARPEN = 2'd2,
        MODE_BRIGHT  = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE   = 3'd0,
        CFG_OFFSET = 3'd1,
        CFG_KEEP   = 3'd2,
        CFG_WIDTH  = 3'd3,
        CFG_HEIGHT = 3'd4
    } t_cfg_idx;

    localparam t_mode            RST_MODE   = MODE_PASS;
    localparam logic [8:0]       RST_OFFSET = 9'd10;
    localparam logic [2:0]       RST_KEEP   = 3'b111;
    localparam logic [DIM_W-1:0] RST_WIDTH  = 9'd200;
    localparam logic [DIM_W-1:0] RST_HEIGHT = 9'd200;

    // channel 0 red, 1 green, 2 blue
    typedef logic [2:0][7:0] t_px;
    // [row][column], row 0 on top, column 2 newest
    typedef t_px [2:0][2:0] t_win;

    typedef struct packed {
        t_px upper;
        t_px middle;
    } t_line;

    typedef struct packed {
        logic vld;
        logic border;
        logic eof;
    } t_ctl;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       eof;
    } t_res;

endpackage

/* design/rgbf_pix_if.sv */
interface rgbf_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       is_flush;

    modport source (output valid, red_in, green_in, blue_in, is_flush, input ready);
    modport sink (input valid, red_in, green_in, blue_in, is_flush, output ready);
endinterface

/* design/rgbf_res_if.sv */
interface rgbf_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       end_of_frame;

    modport source (output valid, red_out, green_out, blue_out, end_of_frame, input ready);
    modport sink (input valid, red_out, green_out, blue_out, end_of_frame, output ready);
endinterface

/* design/rgbf_ram.sv */
module rgbf_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* design/rgbf_filter.sv */
module rgbf_filter
    import rgbf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_win       i_win,
    input  t_ctl       i_ctl,
    input  t_mode      i_mode,
    input  logic [8:0] i_offset,
    input  logic [2:0] i_keep,
    output logic       o_push,
    output t_res       o_data
);
    logic [2:0][SUM_W-1:0] n_sum;
    logic [2:0][SUM_W-1:0] r_sum;
    t_px                   r_ctr;
    t_ctl                  r_ctl;
    t_px                   res_px;

    function automatic logic [7:0] sat8(input logic signed [ARITH_W-1:0] v);
        logic [7:0] s;
        if (v < 0) begin
            s = 8'd0;
        end else if (v > ARITH_W'(255)) begin
            s = 8'd255;
        end else begin
            s = v[7:0];
        end
        return s;
    endfunction

    // stage A: window sums
    always_comb begin
        logic [SUM_W-1:0] row_sum [3];
        for (int k = 0; k < 3; k++) begin
            for (int a = 0; a < 3; a++) begin
                row_sum[a] = SUM_W'(i_win[a][0][k]) + SUM_W'(i_win[a][1][k])
                           + SUM_W'(i_win[a][2][k]);
            end
            n_sum[k] = row_sum[0] + row_sum[1] + row_sum[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
        r_sum <= n_sum;
        r_ctr <= i_win[1][1];
    end

    // stage B: kernel, saturate, mask
    always_comb begin
        logic [SUM_W+13:0]          prod;
        logic signed [ARITH_W-1:0]  ctr_s;
        logic signed [ARITH_W-1:0]  sum_s;
        logic signed [ARITH_W-1:0]  off_s;
        logic signed [ARITH_W-1:0]  v;
        for (int k = 0; k < 3; k++) begin
            prod  = (SUM_W+14)'(r_sum[k]) * (SUM_W+14)'(BLUR_RECIP);
            ctr_s = $signed(ARITH_W'(r_ctr[k]));
            sum_s = $signed(ARITH_W'(r_sum[k]));
            off_s = ARITH_W'($signed(i_offset));
            v     = ctr_s;
            unique case (i_mode)
                MODE_PASS: begin
                    v = ctr_s;
                end
                MODE_BLUR: begin
                    if (!r_ctl.border) begin
                        v = $signed(ARITH_W'(prod[BLUR_SHIFT +: 8]));
                    end
                end
                MODE_SHARPEN: begin
                    if (!r_ctl.border) begin
                        v = ctr_s * ARITH_W'(SHARP_GAIN) - sum_s;
                    end
                end
                MODE_BRIGHT: begin
                    v = ctr_s + off_s;
                end
                default: begin
                    v = ctr_s;
                end
            endcase
            res_px[k] = i_keep[k] ? sat8(v) : 8'd0;
        end
    end

    assign o_push = r_ctl.vld;
    assign o_data = '{red: res_px[0], green: res_px[1], blue: res_px[2], eof: r_ctl.eof};
endmodule

/* design/rgbf_out_fifo.sv */
module rgbf_out_fifo
    import rgbf_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  t_res         i_data,
    rgbf_res_if.source   o_res
);
    t_res                 r_mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] r_wp;
    logic [OUT_PTR_W-1:0] r_rp;
    logic [OUT_PTR_W:0]   r_cnt;
    logic                 pop;

    assign o_res.valid        = (r_cnt != '0);
    assign o_res.red_out      = r_mem[r_rp].red;
    assign o_res.green_out    = r_mem[r_rp].green;
    assign o_res.blue_out     = r_mem[r_rp].blue;
    assign o_res.end_of_frame = r_mem[r_rp].eof;
    assign pop                = o_res.valid && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (OUT_PTR_W+1)'(i_push) - (OUT_PTR_W+1)'(pop);
        end
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule

/* design/rgb_3x3_filter_stream_core.sv */
// Throughput: one item per cycle; the input stalls only while eight released results are outstanding.
// The result released by an item passes the line memory read at acceptance, then window shift,
// window sums and kernel into the queue before it is offered.
// A pixel's result is released by the item W+1 places later in the stream.
// Reset (i_rst_n low, synchronous) clears counters, window, pipeline, queue and loads
// the default registers; the line memory is not cleared and needs no clearing pass.
module rgb_3x3_filter_stream_core
    import rgbf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    rgbf_pix_if.sink              i_pix,
    rgbf_res_if.source            o_res
);
    t_mode              r_mode;
    logic [8:0]         r_offset;
    logic [2:0]         r_keep;
    logic [DIM_W-1:0]   r_fw;
    logic [DIM_W-1:0]   r_fh;

    logic [LINE_AW-1:0] r_col;
    logic [ROW_W-1:0]   r_row;
    logic [CREDIT_W-1:0] r_credit;

    logic               r_s1_vld;
    logic [LINE_AW-1:0] r_s1_col;
    t_px                r_s1_px;
    t_ctl               r_s1_ctl;
    logic               r_s1_fwd;
    t_line              r_last_wr;
    t_win               r_win;
    t_ctl               r_s2;

    logic [DIM_W-1:0]   w_eff;
    logic [DIM_W-1:0]   h_eff;
    logic               restart;
    logic [LINE_AW-1:0] c_sel;
    logic [ROW_W-1:0]   r_sel;
    logic               emit;
    logic               border;
    logic               eof;
    logic [ROW_W-1:0]   pr;
    logic [DIM_W-1:0]   pc;
    logic [LINE_AW-1:0] n_col;
    logic [ROW_W-1:0]   n_row;
    t_px                px;
    logic               acc;
    logic               pop;
    t_line              ram_rd;
    t_line              line;
    t_line              wdata;
    logic               push;
    t_res               push_data;

    assign i_pix.ready = (r_credit < CREDIT_W'(OUT_DEPTH));
    assign acc         = i_pix.valid && i_pix.ready;
    assign pop         = o_res.valid && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= RST_MODE;
            r_offset <= RST_OFFSET;
            r_keep   <= RST_KEEP;
            r_fw     <= RST_WIDTH;
            r_fh     <= RST_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODE:   r_mode   <= t_mode'(i_cfg_data[1:0]);
                CFG_OFFSET: r_offset <= i_cfg_data[8:0];
                CFG_KEEP:   r_keep   <= i_cfg_data[2:0];
                CFG_WIDTH:  r_fw     <= i_cfg_data[DIM_W-1:0];
                CFG_HEIGHT: r_fh     <= i_cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // frame position of the incoming item
    always_comb begin
        logic [DIM_W-1:0] c_inc;
        w_eff = r_fw;
        if (r_fw < DIM_W'(MIN_DIM)) begin
            w_eff = DIM_W'(MIN_DIM);
        end else if (r_fw > DIM_W'(MAX_WIDTH)) begin
            w_eff = DIM_W'(MAX_WIDTH);
        end
        h_eff = r_fh;
        if (r_fh < DIM_W'(MIN_DIM)) begin
            h_eff = DIM_W'(MIN_DIM);
        end else if (r_fh > DIM_W'(MAX_HEIGHT)) begin
            h_eff = DIM_W'(MAX_HEIGHT);
        end

        // restart when the position lies beyond the current geometry
        restart = (DIM_W'(r_col) >= w_eff) || (RC_W'(r_row) > (RC_W'(h_eff) + RC_W'(1)));
        c_sel   = restart ? '0 : r_col;
        r_sel   = restart ? '0 : r_row;

        emit = (r_sel >= ROW_W'(2)) || ((r_sel == ROW_W'(1)) && (c_sel != '0));
        if (c_sel != '0) begin
            pr = r_sel - ROW_W'(1);
            pc = DIM_W'(c_sel) - DIM_W'(1);
        end else begin
            pr = r_sel - ROW_W'(2);
            pc = w_eff - DIM_W'(1);
        end
        border = (pr == '0) || (pr == ROW_W'(h_eff - DIM_W'(1)))
              || (pc == '0) || (pc == w_eff - DIM_W'(1));
        eof    = emit && (pr == ROW_W'(h_eff - DIM_W'(1))) && (pc == w_eff - DIM_W'(1));

        c_inc = DIM_W'(c_sel) + DIM_W'(1);
        if (eof) begin
            n_col = '0;
            n_row = '0;
        end else if (c_inc >= w_eff) begin
            n_col = '0;
            n_row = r_sel + ROW_W'(1);
        end else begin
            n_col = c_inc[LINE_AW-1:0];
            n_row = r_sel;
        end

        px = i_pix.is_flush ? '0 : t_px'({i_pix.blue_in, i_pix.green_in, i_pix.red_in});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_credit <= '0;
        end else begin
            if (acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            r_credit <= r_credit + CREDIT_W'(acc && emit) - CREDIT_W'(pop);
        end
    end

    rgbf_ram #(
        .WIDTH ($bits(t_line)),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_vld),
        .i_waddr (r_s1_col),
        .i_wdata (wdata),
        .i_raddr (c_sel),
        .o_rdata (ram_rd)
    );

    // take the write in flight when it hit the column just read
    assign line  = r_s1_fwd ? r_last_wr : ram_rd;
    assign wdata = '{upper: line.middle, middle: r_s1_px};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s1_fwd <= 1'b0;
            r_win    <= '0;
            r_s2     <= '0;
        end else begin
            r_s1_vld <= acc;
            if (acc) begin
                r_s1_fwd <= r_s1_vld && (r_s1_col == c_sel);
            end
            if (r_s1_vld) begin
                for (int a = 0; a < 3; a++) begin
                    r_win[a][0] <= r_win[a][1];
                    r_win[a][1] <= r_win[a][2];
                end
                r_win[0][2] <= line.upper;
                r_win[1][2] <= line.middle;
                r_win[2][2] <= r_s1_px;
            end
            r_s2 <= '{vld: r_s1_vld && r_s1_ctl.vld, border: r_s1_ctl.border,
                      eof: r_s1_ctl.eof};
        end
        if (acc) begin
            r_s1_col <= c_sel;
            r_s1_px  <= px;
            r_s1_ctl <= '{vld: emit, border: border, eof: eof};
        end
        if (r_s1_vld) begin
            r_last_wr <= wdata;
        end
    end

    rgbf_filter u_filter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_win    (r_win),
        .i_ctl    (r_s2),
        .i_mode   (r_mode),
        .i_offset (r_offset),
        .i_keep   (r_keep),
        .o_push   (push),
        .o_data   (push_data)
    );

    rgbf_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_res   (o_res)
    );

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= CREDIT_W'(OUT_DEPTH))
        else $error("result credit above queue depth");

    a_valid_has_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (r_credit != '0))
        else $error("result offered without an outstanding item");

    a_forward_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && r_s1_vld && (r_s1_col == c_sel)) |=> (r_s1_vld && r_s1_fwd))
        else $error("same-column line access not forwarded");

    a_s2_from_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2.vld |-> $past(r_s1_vld))
        else $error("window stage valid without a line stage item");
endmodule
